@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition true at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/bci_pkg.sv @@
// ----------------------------------------------------------------------------
// bci_pkg
// Shared widths, register indexes, point field helpers and stage payloads.
// ----------------------------------------------------------------------------
package bci_pkg;

    localparam int VOLT_W         = 16;
    localparam int PCT_W          = 7;
    localparam int POINT_W        = 23;
    localparam int CNT_W          = 3;
    localparam int REG_POINTS     = 7;
    localparam int MAX_POINTS_DEF = 7;
    localparam int PROD_W         = VOLT_W + PCT_W;
    localparam int QUO_W          = PCT_W;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STAGES     = (QUO_W + DIV_BITS - 1) / DIV_BITS;
    localparam int REG_IDX_W      = 3;
    localparam int ADDR_W         = 5;
    localparam int APB_DATA_W     = 32;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 8;

    localparam logic [REG_IDX_W-1:0] REG_COUNT       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;

    typedef struct packed {
        logic [VOLT_W-1:0] num;
        logic [VOLT_W-1:0] span;
        logic [PCT_W-1:0]  mag;
        logic              neg;
        logic [PCT_W-1:0]  base;
        logic              interp;
    } sel_t;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [VOLT_W-1:0] span;
        logic              neg;
        logic [PCT_W-1:0]  base;
        logic              interp;
    } div_t;

    function automatic logic [VOLT_W-1:0] pt_volt(input logic [POINT_W-1:0] pt);
        return pt[VOLT_W-1:0];
    endfunction

    function automatic logic [PCT_W-1:0] pt_pct(input logic [POINT_W-1:0] pt);
        return pt[POINT_W-1:VOLT_W];
    endfunction

endpackage

@@ hdl/battery_curve_interpolator.sv @@
// Pipeline from accepted sample to result word: 2 locate, 1 multiply, 4 divide
// stages at up to two quotient bits per stage, 1 output register.
// Throughput: one word per cycle; each stage holds its word while the next is full.
// Reset clears the point count, all curve points and every stage valid bit.
// ----------------------------------------------------------------------------
// battery_curve_interpolator
// Voltage to charge lookup over a piecewise linear curve of up to seven points.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_curve_interpolator #(
    parameter int MAX_POINTS = bci_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bci_pkg::ADDR_W-1:0]      paddr,
    input  logic [bci_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bci_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // sample in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bci_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] sample_voltage
    // charge out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bci_pkg::OUT_DATA_W-1:0]  m_tdata   // [6:0] charge_percent, [7] zero
);

    logic [bci_pkg::CNT_W-1:0]     count_reg;
    logic [bci_pkg::POINT_W-1:0]   point_reg [bci_pkg::REG_POINTS];
    logic [bci_pkg::REG_IDX_W-1:0] reg_idx;
    logic [bci_pkg::REG_IDX_W-1:0] pt_idx;
    logic                          wr_en;

    logic                          mid_valid;
    logic                          mid_ready;
    bci_pkg::sel_t                 sel;
    logic [bci_pkg::PCT_W-1:0]     charge;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bci_pkg::ADDR_W-1:2];
    assign pt_idx  = reg_idx - bci_pkg::REG_POINT_FIRST;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < bci_pkg::REG_POINTS; i++)
                point_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == bci_pkg::REG_COUNT)
                count_reg <= pwdata[bci_pkg::CNT_W-1:0];
            else
                point_reg[pt_idx] <= pwdata[bci_pkg::POINT_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == bci_pkg::REG_COUNT)
            prdata = bci_pkg::APB_DATA_W'(count_reg);
        else
            prdata = bci_pkg::APB_DATA_W'(point_reg[pt_idx]);
    end

    bci_locate #(
        .MAX_POINTS (MAX_POINTS)
    ) u_locate (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata[bci_pkg::VOLT_W-1:0]),
        .point_count (count_reg),
        .points      (point_reg),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .sel         (sel)
    );

    bci_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .sel       (sel),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .charge    (charge)
    );

    assign m_tdata = bci_pkg::OUT_DATA_W'(charge);

    `ASSERT_IMPLY(a_ready_when_drained, !m_tvalid, s_tready, "input stalled with empty output")
    `ASSERT_IMPLY(a_span_nonzero, mid_valid && sel.interp, sel.span != '0, "zero divisor")
    `ASSERT_IMPLY(a_excess_below_span, mid_valid && sel.interp, sel.num < sel.span,
                  "voltage excess not below span")
    `ASSERT_ALWAYS(a_pad_zero, !m_tvalid || !m_tdata[bci_pkg::OUT_DATA_W-1], "pad bit set")

endmodule

@@ hdl/bci_locate.sv @@
// ----------------------------------------------------------------------------
// bci_locate
// Two stages: compare the sample with every active point and mark the first
// one reached, then pick the bracketing pair and form the division operands.
// ----------------------------------------------------------------------------
module bci_locate #(
    parameter int MAX_POINTS = bci_pkg::MAX_POINTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bci_pkg::VOLT_W-1:0]  sample,
    input  logic [bci_pkg::CNT_W-1:0]   point_count,
    input  logic [bci_pkg::POINT_W-1:0] points [bci_pkg::REG_POINTS],
    output logic                        out_valid,
    input  logic                        out_ready,
    output bci_pkg::sel_t               sel
);

    localparam logic [bci_pkg::CNT_W-1:0] CNT_MAX = bci_pkg::CNT_W'(MAX_POINTS);

    logic                        a_valid_reg;
    logic [bci_pkg::VOLT_W-1:0]  a_sample_reg;
    logic [MAX_POINTS-1:0]       a_first_reg;
    logic [MAX_POINTS-1:0]       a_first_next;
    logic                        a_ready;

    logic                        b_valid_reg;
    bci_pkg::sel_t               b_sel_reg;
    bci_pkg::sel_t               b_sel_next;
    logic                        b_ready;

    logic [bci_pkg::CNT_W-1:0]   n_used;
    logic [bci_pkg::VOLT_W-1:0]  v0;
    logic [bci_pkg::VOLT_W-1:0]  v1;
    logic [bci_pkg::PCT_W-1:0]   p0;
    logic [bci_pkg::PCT_W-1:0]   p1;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    assign n_used = (point_count > CNT_MAX) ? CNT_MAX : point_count;

    always_comb
    begin
        logic taken;
        logic hit;
        taken        = 1'b0;
        a_first_next = '0;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            hit = (bci_pkg::CNT_W'(i) < n_used) &&
                  (sample >= bci_pkg::pt_volt(points[i]));
            a_first_next[i] = hit && !taken;
            taken = taken || hit;
        end
    end

    always_comb
    begin
        v0 = '0;
        v1 = '0;
        p0 = '0;
        p1 = '0;
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            v1 = v1 | ({bci_pkg::VOLT_W{a_first_reg[j]}} & bci_pkg::pt_volt(points[j]));
            p1 = p1 | ({bci_pkg::PCT_W{a_first_reg[j]}} & bci_pkg::pt_pct(points[j]));
        end
        for (int j = 1; j < MAX_POINTS; j++)
        begin
            v0 = v0 | ({bci_pkg::VOLT_W{a_first_reg[j]}} & bci_pkg::pt_volt(points[j-1]));
            p0 = p0 | ({bci_pkg::PCT_W{a_first_reg[j]}} & bci_pkg::pt_pct(points[j-1]));
        end
        b_sel_next.num    = a_sample_reg - v1;
        b_sel_next.span   = v0 - v1;
        b_sel_next.neg    = p0 < p1;
        b_sel_next.mag    = (p0 < p1) ? (p1 - p0) : (p0 - p1);
        b_sel_next.base   = p1;
        b_sel_next.interp = |a_first_reg[MAX_POINTS-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_sample_reg <= sample;
            a_first_reg  <= a_first_next;
        end
        if (b_ready && a_valid_reg)
            b_sel_reg <= b_sel_next;
    end

    assign out_valid = b_valid_reg;
    assign sel       = b_sel_reg;

endmodule

@@ hdl/bci_divide.sv @@
// ----------------------------------------------------------------------------
// bci_divide
// Multiply the voltage excess by the percentage span, divide by the voltage
// span in restoring steps over several stages, then add the signed quotient.
// ----------------------------------------------------------------------------
module bci_divide (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bci_pkg::sel_t             sel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bci_pkg::PCT_W-1:0] charge
);

    localparam int NST = bci_pkg::DIV_STAGES + 1;

    logic           v_reg   [NST];
    bci_pkg::div_t  d_reg   [NST];
    bci_pkg::div_t  d_next  [NST];
    logic           rdy     [NST+1];
    logic           v_prev  [NST];

    logic                      out_valid_reg;
    logic [bci_pkg::PCT_W-1:0] charge_reg;
    logic [bci_pkg::PCT_W-1:0] charge_next;
    logic [bci_pkg::QUO_W-1:0] q;

    assign rdy[NST]  = !out_valid_reg || out_ready;
    assign in_ready  = rdy[0];
    assign v_prev[0] = in_valid;

    always_comb
    begin
        d_next[0].rem    = bci_pkg::PROD_W'(sel.num) * bci_pkg::PROD_W'(sel.mag);
        d_next[0].quo    = '0;
        d_next[0].span   = sel.span;
        d_next[0].neg    = sel.neg;
        d_next[0].base   = sel.base;
        d_next[0].interp = sel.interp;
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k > 0)
        begin : g_div
            assign v_prev[k] = v_reg[k-1];

            always_comb
            begin
                bci_pkg::div_t             t;
                logic [bci_pkg::PROD_W-1:0] trial;
                int                         bit_pos;
                t = d_reg[k-1];
                for (int b = 0; b < bci_pkg::DIV_BITS; b++)
                begin
                    bit_pos = bci_pkg::QUO_W - 1 - (k - 1) * bci_pkg::DIV_BITS - b;
                    if (bit_pos >= 0)
                    begin
                        trial = bci_pkg::PROD_W'(t.span) << bit_pos;
                        if (t.rem >= trial)
                        begin
                            t.rem = t.rem - trial;
                            t.quo = {t.quo[bci_pkg::QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            t.quo = {t.quo[bci_pkg::QUO_W-2:0], 1'b0};
                        end
                    end
                end
                d_next[k] = t;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= v_prev[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && v_prev[k])
                d_reg[k] <= d_next[k];
        end
    end

    always_comb
    begin
        q           = d_reg[NST-1].interp ? d_reg[NST-1].quo : '0;
        charge_next = d_reg[NST-1].neg ? (d_reg[NST-1].base - q) : (d_reg[NST-1].base + q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy[NST])
            out_valid_reg <= v_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST] && v_reg[NST-1])
            charge_reg <= charge_next;
    end

    assign out_valid = out_valid_reg;
    assign charge    = charge_reg;

endmodule
